/* rtl/core/mpd_pkg.sv */
`timescale 1ns / 1ps

package mpd_pkg;

    localparam int MAX_WIDTH_DEF    = 4096;
    localparam int MAX_LEVELS_DEF   = 6;
    localparam int CHANNEL_BITS_DEF = 16;

    localparam int MAX_HEIGHT       = 4096;
    localparam int ROW_BITS         = 12;
    localparam int SIZE_BITS        = 13;
    localparam int LEVEL_BITS       = 3;
    localparam int COORD_BITS       = 11;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int CFG_DATA_BITS    = 13;

    localparam logic [SIZE_BITS-1:0]  WIDTH_RESET  = SIZE_BITS'(4096);
    localparam logic [SIZE_BITS-1:0]  HEIGHT_RESET = SIZE_BITS'(4096);
    localparam logic [LEVEL_BITS-1:0] LEVELS_RESET = LEVEL_BITS'(6);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_LEVEL_COUNT  = 2'd2
    } reg_index_t;

endpackage

/* rtl/core/mpd_ifs.sv */
`timescale 1ns / 1ps

interface mpd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [mpd_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [mpd_pkg::CFG_DATA_BITS-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface mpd_pix_in_if #(parameter int CHANNEL_BITS = mpd_pkg::CHANNEL_BITS_DEF);
    logic                    valid;
    logic                    ready;
    logic                    start_of_frame;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic [CHANNEL_BITS-1:0] alpha;
    modport source (output valid, start_of_frame, red, green, blue, alpha, input ready);
    modport sink (input valid, start_of_frame, red, green, blue, alpha, output ready);
endinterface

interface mpd_pix_out_if #(parameter int CHANNEL_BITS = mpd_pkg::CHANNEL_BITS_DEF);
    logic                              valid;
    logic                              ready;
    logic [mpd_pkg::LEVEL_BITS-1:0]    level;
    logic [mpd_pkg::COORD_BITS-1:0]    column;
    logic [mpd_pkg::COORD_BITS-1:0]    row;
    logic [CHANNEL_BITS-1:0]           out_red;
    logic [CHANNEL_BITS-1:0]           out_green;
    logic [CHANNEL_BITS-1:0]           out_blue;
    logic [CHANNEL_BITS-1:0]           out_alpha;
    logic                              last_of_run;
    modport source (output valid, level, column, row, out_red, out_green, out_blue,
                    out_alpha, last_of_run, input ready);
    modport sink (input valid, level, column, row, out_red, out_green, out_blue,
                  out_alpha, last_of_run, output ready);
endinterface

/* rtl/core/mip_pyramid_box_downsampler.sv */
`timescale 1ns / 1ps
// Streaming 2x2 box-filter mip pyramid, levels 1..level_count.
// Throughput: one pixel per cycle; each reduced pixel that feeds a further level holds
// off the input, as does a result queue without room for a full run.
// First result queued in the cycle after the pixel transfer, valid out in the next one.
// Reset: config to 4096 x 4096, 6 levels; position to first pixel; queue empty.
// Line RAM and held pixels are not cleared.
module mip_pyramid_box_downsampler #(
    parameter int MAX_WIDTH    = mpd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_LEVELS   = mpd_pkg::MAX_LEVELS_DEF,
    parameter int CHANNEL_BITS = mpd_pkg::CHANNEL_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mpd_cfg_if.sink              cfg,
    mpd_pix_in_if.sink           pix_in,
    mpd_pix_out_if.source        pix_out
);

    localparam int CB   = CHANNEL_BITS;
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CWW  = (WW > mpd_pkg::SIZE_BITS) ? WW : mpd_pkg::SIZE_BITS;
    localparam int KW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int LVW  = $clog2(MAX_LEVELS + 1);
    localparam int LCW  = (LVW > mpd_pkg::LEVEL_BITS) ? LVW : mpd_pkg::LEVEL_BITS;
    localparam int RW   = mpd_pkg::ROW_BITS;
    localparam int SW   = mpd_pkg::SIZE_BITS;
    localparam int FD   = 2 ** $clog2(MAX_LEVELS + 2);
    localparam int FAW  = $clog2(FD);
    localparam int LIMIT = FD - MAX_LEVELS;
    localparam logic [XW:0] MW = (XW + 1)'(MAX_WIDTH);

    typedef logic [3:0][CB-1:0] px_t;
    typedef logic [3:0][CB:0]   pair_t;

    typedef struct packed {
        logic [mpd_pkg::LEVEL_BITS-1:0] level;
        logic [mpd_pkg::COORD_BITS-1:0] column;
        logic [mpd_pkg::COORD_BITS-1:0] row;
        px_t                            px;
        logic                           last;
    } res_t;

    // configuration
    logic [SW-1:0]                   width_reg;
    logic [SW-1:0]                   height_reg;
    logic [mpd_pkg::LEVEL_BITS-1:0]  levels_reg;
    logic [WW-1:0]                   w_eff;
    logic [SW-1:0]                   h_eff;
    logic [LVW-1:0]                  lv_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mpd_pkg::WIDTH_RESET;
            height_reg <= mpd_pkg::HEIGHT_RESET;
            levels_reg <= mpd_pkg::LEVELS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                mpd_pkg::REG_IMAGE_WIDTH:  width_reg  <= SW'(cfg.data);
                mpd_pkg::REG_IMAGE_HEIGHT: height_reg <= SW'(cfg.data);
                mpd_pkg::REG_LEVEL_COUNT:  levels_reg <= mpd_pkg::LEVEL_BITS'(cfg.data);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (CWW'(width_reg) > CWW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = SW'(1);
        else if (height_reg > SW'(mpd_pkg::MAX_HEIGHT))
            h_eff = SW'(mpd_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;

        if (LCW'(levels_reg) > LCW'(MAX_LEVELS))
            lv_eff = LVW'(MAX_LEVELS);
        else
            lv_eff = LVW'(levels_reg);
    end

    // position
    logic [XW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [XW-1:0] c0, cur_x;
    logic [RW-1:0] r0, cur_y;
    logic [SW-1:0] r1, rn;
    logic [WW-1:0] cn;

    always_comb
    begin
        c0 = pix_in.start_of_frame ? '0 : col_reg;
        r0 = pix_in.start_of_frame ? '0 : row_reg;
        if (WW'(c0) >= w_eff)
        begin
            cur_x = '0;
            r1    = SW'(r0) + SW'(1);
        end
        else
        begin
            cur_x = c0;
            r1    = SW'(r0);
        end
        cur_y = (r1 >= h_eff) ? '0 : RW'(r1);

        cn = WW'(cur_x) + WW'(1);
        rn = SW'(cur_y) + SW'(1);
        if (cn >= w_eff)
        begin
            col_next = '0;
            row_next = (rn >= h_eff) ? '0 : RW'(rn);
        end
        else
        begin
            col_next = XW'(cn);
            row_next = cur_y;
        end
    end

    // level sequencer: stage A decodes one level op, stage B averages
    logic              b_valid_reg;
    logic [KW-1:0]     b_k_reg;
    logic [XW-1:0]     b_x_reg;
    logic [RW-1:0]     b_y_reg;
    pair_t             b_part_reg;
    pair_t             line_rd;
    px_t               b_avg;
    logic [LVW-1:0]    b_k1;
    logic              b_next_exists;
    logic              fb;

    logic [FAW:0]      cnt_reg, cnt_next;
    logic [FAW-1:0]    wr_ptr_reg, rd_ptr_reg;
    res_t              fifo_mem [FD];
    res_t              push_data;
    logic              push, pop;

    logic              take_in;
    logic              op_valid;
    logic [KW-1:0]     op_k;
    logic [XW-1:0]     op_x;
    logic [RW-1:0]     op_y;
    px_t               op_px;
    px_t               held_rd;
    pair_t             op_pair;
    logic [XW:0]       idx_full;
    logic [XW-1:0]     idx;
    logic              ram_we, ram_re;
    px_t               held_reg [MAX_LEVELS];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            b_avg[c] = CB'(((CB + 2)'(line_rd[c]) + (CB + 2)'(b_part_reg[c])) >> 2);
        end
        b_k1          = LVW'(b_k_reg) + LVW'(1);
        b_next_exists = (b_k1 < lv_eff) && ((MW >> b_k1) != '0);
        fb            = b_valid_reg && b_next_exists;
    end

    assign pix_in.ready = !fb && ((FAW + 1)'(cnt_reg) + (FAW + 1)'(b_valid_reg)
                                  <= (FAW + 1)'(LIMIT));
    assign take_in = pix_in.valid && pix_in.ready;

    always_comb
    begin
        if (fb)
        begin
            op_valid = 1'b1;
            op_k     = KW'(b_k1);
            op_x     = b_x_reg >> 1;
            op_y     = b_y_reg >> 1;
            op_px    = b_avg;
        end
        else
        begin
            op_valid = take_in && (lv_eff != '0);
            op_k     = '0;
            op_x     = cur_x;
            op_y     = cur_y;
            op_px    = {pix_in.alpha, pix_in.blue, pix_in.green, pix_in.red};
        end
        held_rd = held_reg[op_k];
        for (int c = 0; c < 4; c++)
        begin
            op_pair[c] = (CB + 1)'(held_rd[c]) + (CB + 1)'(op_px[c]);
        end
        idx_full = (MW - (MW >> op_k)) + (XW + 1)'(op_x >> 1);
        idx      = idx_full[XW-1:0];
        ram_we   = op_valid && op_x[0] && !op_y[0];
        ram_re   = op_valid && op_x[0] && op_y[0];
    end

    mpd_ram #(
        .WIDTH (4 * (CB + 1)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (op_pair),
        .re    (ram_re),
        .raddr (idx),
        .rdata (line_rd)
    );

    always_ff @(posedge clk)
    begin
        if (op_valid && !op_x[0])
        begin
            held_reg[op_k] <= op_px;
        end
        if (ram_re)
        begin
            b_k_reg    <= op_k;
            b_x_reg    <= op_x;
            b_y_reg    <= op_y;
            b_part_reg <= op_pair;
        end
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
        end
        else
        begin
            if (take_in)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            b_valid_reg <= ram_re;
            cnt_reg     <= cnt_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FAW'(1);
        end
    end

    // result queue
    assign push = b_valid_reg;
    assign pop  = pix_out.valid && pix_out.ready;
    assign cnt_next = cnt_reg + (FAW + 1)'(push) - (FAW + 1)'(pop);

    always_comb
    begin
        push_data.level  = mpd_pkg::LEVEL_BITS'(b_k1);
        push_data.column = mpd_pkg::COORD_BITS'(b_x_reg >> 1);
        push_data.row    = mpd_pkg::COORD_BITS'(b_y_reg >> 1);
        push_data.px     = b_avg;
        push_data.last   = !(b_next_exists && b_x_reg[1] && b_y_reg[1]);
    end

    assign pix_out.valid       = (cnt_reg != '0);
    assign pix_out.level       = fifo_mem[rd_ptr_reg].level;
    assign pix_out.column      = fifo_mem[rd_ptr_reg].column;
    assign pix_out.row         = fifo_mem[rd_ptr_reg].row;
    assign pix_out.out_red     = fifo_mem[rd_ptr_reg].px[0];
    assign pix_out.out_green   = fifo_mem[rd_ptr_reg].px[1];
    assign pix_out.out_blue    = fifo_mem[rd_ptr_reg].px[2];
    assign pix_out.out_alpha   = fifo_mem[rd_ptr_reg].px[3];
    assign pix_out.last_of_run = fifo_mem[rd_ptr_reg].last;

endmodule

/* rtl/core/mpd_ram.sv */
`timescale 1ns / 1ps

module mpd_ram #(
    parameter int WIDTH = 68,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
